// File: hdl/urb_pkg.sv
package urb_pkg;

  // Ring sizes. Each ring holds one byte fewer than its depth.
  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_AW    = $clog2(TX_DEPTH);

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // Event codes carried by op.
  localparam logic [OP_W-1:0] OP_RX_BYTE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ    = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE   = 3'd2;
  localparam logic [OP_W-1:0] OP_TX_RDY  = 3'd3;
  localparam logic [OP_W-1:0] OP_DISABLE = 3'd4;

  // Status codes returned with each result.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RX_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TX_FULL  = 2'd2;

endpackage

// File: hdl/uart_rx_tx_ring_buffers.sv
// Channel   Direction  Handshake            Beat contents
// -------   ---------  -------------------  ---------------------------------------------
// event     in         in_valid / in_ready  op, rx_byte, frame_error, write_byte,
//                                           tx_reg_empty
// result    out        out_valid/out_ready  read_byte, status, line_byte, line_valid,
//                                           rx_count, tx_irq_enable
//
// The cycle that accepts an event updates the ring pointers and issues at most
// one access to each ring memory, and the following cycle collects the registered
// read data into the result register. The ring memories have a registered read
// port, so no new event is taken until this result has been collected.
// Reset (rst, synchronous) empties both rings and clears the interrupt enable; the
// memory contents are not cleared. A stalled result holds its register and blocks
// the next event until the result beat is taken.
module uart_rx_tx_ring_buffers
  import urb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [7:0]          rx_byte,
  input  logic                frame_error,
  input  logic [7:0]          write_byte,
  input  logic                tx_reg_empty,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          read_byte,
  output logic [STATUS_W-1:0] status,
  output logic [7:0]          line_byte,
  output logic                line_valid,
  output logic [COUNT_W-1:0]  rx_count,
  output logic                tx_irq_enable
);

  typedef enum logic {
    S_IDLE,
    S_FINISH
  } state_t;

  state_t state;

  // Ring pointers: head is the next slot to fill, tail the next to empty.
  logic [RX_AW-1:0] rx_head, rx_tail;
  logic [TX_AW-1:0] tx_head, tx_tail;
  logic             irq_on;

  // What the finishing cycle has to assemble.
  logic                pend_rd;
  logic                pend_tx_mem;
  logic                pend_direct;
  logic [7:0]          direct_byte;
  logic [STATUS_W-1:0] pend_status;

  logic accept;

  // Successor slots, wrapping at the depth so that any depth works.
  logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;
  logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;

  assign rx_head_inc = (rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head + RX_AW'(1);
  assign rx_tail_inc = (rx_tail == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail + RX_AW'(1);
  assign tx_head_inc = (tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head + TX_AW'(1);
  assign tx_tail_inc = (tx_tail == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail + TX_AW'(1);

  logic rx_empty, tx_empty;
  assign rx_empty = (rx_head == rx_tail);
  assign tx_empty = (tx_head == tx_tail);

  // Decisions taken while an event is offered.
  logic                rx_we, rx_re, tx_we, tx_re;
  logic                direct_send;
  logic                irq_set, irq_clr;
  logic                rx_flush;
  logic [STATUS_W-1:0] status_now;

  always_comb begin
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    direct_send = 1'b0;
    irq_set     = 1'b0;
    irq_clr     = 1'b0;
    rx_flush    = 1'b0;
    status_now  = ST_OK;
    case (op)
      OP_RX_BYTE: begin
        // A byte with a frame error, or one that finds the ring full, is lost.
        rx_we = !frame_error && (rx_head_inc != rx_tail);
      end
      OP_READ: begin
        if (rx_empty) begin
          status_now = ST_RX_EMPTY;
        end else begin
          rx_re = 1'b1;
        end
      end
      OP_WRITE: begin
        if (tx_empty && tx_reg_empty) begin
          direct_send = 1'b1;
        end else begin
          irq_set = 1'b1;
          if (tx_head_inc == tx_tail) begin
            status_now = ST_TX_FULL;
          end else begin
            tx_we = 1'b1;
          end
        end
      end
      OP_TX_RDY: begin
        tx_re = !tx_empty;
        // The enable drops once the ring is empty after this pop.
        irq_clr = tx_empty || (tx_tail_inc == tx_head);
      end
      OP_DISABLE: begin
        rx_flush = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  logic [7:0] rx_rdata, tx_rdata;

  urb_ram #(
    .DEPTH (RX_DEPTH),
    .WIDTH (8)
  ) u_rx_ram (
    .clk   (clk),
    .we    (accept && rx_we),
    .waddr (rx_head),
    .wdata (rx_byte),
    .re    (accept && rx_re),
    .raddr (rx_tail),
    .rdata (rx_rdata)
  );

  urb_ram #(
    .DEPTH (TX_DEPTH),
    .WIDTH (8)
  ) u_tx_ram (
    .clk   (clk),
    .we    (accept && tx_we),
    .waddr (tx_head),
    .wdata (write_byte),
    .re    (accept && tx_re),
    .raddr (tx_tail),
    .rdata (tx_rdata)
  );

  // Fill level of the receive ring from the pointers as they stand after the event.
  logic [RX_AW:0] rx_fill;
  logic [15:0]    rx_fill_wide;

  always_comb begin
    rx_fill = {1'b0, rx_head} - {1'b0, rx_tail};
    if (rx_head < rx_tail) begin
      rx_fill = rx_fill + (RX_AW + 1)'(RX_DEPTH);
    end
    rx_fill_wide = 16'(rx_fill);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      rx_head     <= '0;
      rx_tail     <= '0;
      tx_head     <= '0;
      tx_tail     <= '0;
      irq_on      <= 1'b0;
      pend_rd     <= 1'b0;
      pend_tx_mem <= 1'b0;
      pend_direct <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state       <= S_FINISH;
            pend_rd     <= rx_re;
            pend_tx_mem <= tx_re;
            pend_direct <= direct_send;
            direct_byte <= write_byte;
            pend_status <= status_now;
            if (rx_we) begin
              rx_head <= rx_head_inc;
            end
            if (rx_re) begin
              rx_tail <= rx_tail_inc;
            end
            if (rx_flush) begin
              rx_head <= rx_tail;
            end
            if (tx_we) begin
              tx_head <= tx_head_inc;
            end
            if (tx_re) begin
              tx_tail <= tx_tail_inc;
            end
            if (irq_set) begin
              irq_on <= 1'b1;
            end else if (irq_clr) begin
              irq_on <= 1'b0;
            end
          end
        end
        S_FINISH: begin
          // The result register was emptied when this event was accepted.
          state         <= S_IDLE;
          out_valid     <= 1'b1;
          read_byte     <= pend_rd ? rx_rdata : 8'd0;
          line_byte     <= pend_tx_mem ? tx_rdata : (pend_direct ? direct_byte : 8'd0);
          line_valid    <= pend_tx_mem || pend_direct;
          status        <= pend_status;
          rx_count      <= rx_fill_wide[COUNT_W-1:0];
          tx_irq_enable <= irq_on;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/urb_ram.sv
module urb_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sim/uart_rx_tx_ring_buffers_checker.sv
module uart_rx_tx_ring_buffers_checker
  import urb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [7:0]          rx_byte,
  input  logic                frame_error,
  input  logic [7:0]          write_byte,
  input  logic                tx_reg_empty,

  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [7:0]          read_byte,
  input  logic [STATUS_W-1:0] status,
  input  logic [7:0]          line_byte,
  input  logic                line_valid,
  input  logic [COUNT_W-1:0]  rx_count,
  input  logic                tx_irq_enable,

  output int                  errors,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]          read_byte;
    logic [STATUS_W-1:0] status;
    logic [7:0]          line_byte;
    logic                line_valid;
    logic [COUNT_W-1:0]  rx_count;
    logic                tx_irq_enable;
  } port_outcome_t;

  // Shadow copy of both rings and the interrupt enable.
  logic [7:0]    rx_ring [RX_DEPTH];
  logic [7:0]    tx_ring [TX_DEPTH];
  int unsigned   rx_wr, rx_rd, tx_wr, tx_rd;
  logic          irq_en;
  port_outcome_t awaited_outcomes [$];
  port_outcome_t want;

  // Applies one event to the shadow state and returns the result it must produce.
  function automatic port_outcome_t serial_port_outcome(input logic [OP_W-1:0] code,
                                                        input logic [7:0] rxd,
                                                        input logic ferr,
                                                        input logic [7:0] wrd,
                                                        input logic treg);
    port_outcome_t res;
    int unsigned   nxt;
    res = '0;
    res.status = ST_OK;
    case (code)
      OP_RX_BYTE: begin
        if (!ferr) begin
          nxt = (rx_wr + 1) % RX_DEPTH;
          // A full ring drops the byte without any indication.
          if (nxt != rx_rd) begin
            rx_ring[rx_wr[RX_AW-1:0]] = rxd;
            rx_wr = nxt;
          end
        end
      end
      OP_READ: begin
        if (rx_wr == rx_rd) begin
          res.status = ST_RX_EMPTY;
        end else begin
          res.read_byte = rx_ring[rx_rd[RX_AW-1:0]];
          rx_rd = (rx_rd + 1) % RX_DEPTH;
        end
      end
      OP_WRITE: begin
        if (tx_wr == tx_rd && treg) begin
          res.line_byte  = wrd;
          res.line_valid = 1'b1;
        end else begin
          nxt = (tx_wr + 1) % TX_DEPTH;
          if (nxt == tx_rd) begin
            res.status = ST_TX_FULL;
          end else begin
            tx_ring[tx_wr[TX_AW-1:0]] = wrd;
            tx_wr = nxt;
          end
          irq_en = 1'b1;
        end
      end
      OP_TX_RDY: begin
        if (tx_wr != tx_rd) begin
          res.line_byte  = tx_ring[tx_rd[TX_AW-1:0]];
          res.line_valid = 1'b1;
          tx_rd = (tx_rd + 1) % TX_DEPTH;
        end
        if (tx_wr == tx_rd) begin
          irq_en = 1'b0;
        end
      end
      OP_DISABLE: begin
        rx_wr = rx_rd;
      end
      default: begin
      end
    endcase
    res.rx_count      = COUNT_W'((RX_DEPTH + rx_wr - rx_rd) % RX_DEPTH);
    res.tx_irq_enable = irq_en;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_val,
                                      input logic [7:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rx_wr = 0;
      rx_rd = 0;
      tx_wr = 0;
      tx_rd = 0;
      irq_en = 1'b0;
      awaited_outcomes.delete();
      errors = 0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_outcomes.push_back(serial_port_outcome(op, rx_byte, frame_error,
                                                       write_byte, tx_reg_empty));
      end
      if (out_valid && out_ready) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result beat arrived with nothing expected");
          errors++;
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("read_byte", want.read_byte, read_byte);
          check_field("status", 8'(want.status), 8'(status));
          check_field("line_byte", want.line_byte, line_byte);
          check_field("line_valid", 8'(want.line_valid), 8'(line_valid));
          check_field("rx_count", 8'(want.rx_count), 8'(rx_count));
          check_field("tx_irq_enable", 8'(want.tx_irq_enable), 8'(tx_irq_enable));
        end
      end
    end
    outstanding = awaited_outcomes.size();
  end

endmodule

// File: sim/uart_rx_tx_ring_buffers_tb.sv
module uart_rx_tx_ring_buffers_tb
  import urb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 11;
  // Settling time after the last result, to catch a stray extra beat.
  localparam int SETTLE_CYCLES = 12;
  // Cycle limit for roughly 1550 events, with generous headroom.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int NUM_SEGMENTS  = 16;
  localparam int SEG_ITEMS     = 96;
  // The final segments run without any idling on either side.
  localparam int CALM_SEGMENTS = 2;

  // Traffic shapes for the random part. Each one but MIXED_TRAFFIC leans on a single
  // event kind so that the rings are driven right up to full and back down to empty.
  typedef enum logic [2:0] {
    MIXED_TRAFFIC,
    FILL_RX,
    DRAIN_RX,
    FILL_TX,
    DRAIN_TX
  } traffic_t;

  logic                clk = 1'b0;
  logic                rst;

  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     op;
  logic [7:0]          rx_byte;
  logic                frame_error;
  logic [7:0]          write_byte;
  logic                tx_reg_empty;

  logic                out_valid;
  logic                out_ready;
  logic [7:0]          read_byte;
  logic [STATUS_W-1:0] status;
  logic [7:0]          line_byte;
  logic                line_valid;
  logic [COUNT_W-1:0]  rx_count;
  logic                tx_irq_enable;

  int                  errors;
  int                  outstanding;
  int                  cycle_count = 0;
  // 0 means no idling, 1 light idling, 2 heavy idling. Both sides follow it.
  int                  idle_level;

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  uart_rx_tx_ring_buffers dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .rx_byte       (rx_byte),
    .frame_error   (frame_error),
    .write_byte    (write_byte),
    .tx_reg_empty  (tx_reg_empty),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_byte     (read_byte),
    .status        (status),
    .line_byte     (line_byte),
    .line_valid    (line_valid),
    .rx_count      (rx_count),
    .tx_irq_enable (tx_irq_enable)
  );

  uart_rx_tx_ring_buffers_checker port_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .rx_byte       (rx_byte),
    .frame_error   (frame_error),
    .write_byte    (write_byte),
    .tx_reg_empty  (tx_reg_empty),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_byte     (read_byte),
    .status        (status),
    .line_byte     (line_byte),
    .line_valid    (line_valid),
    .rx_count      (rx_count),
    .tx_irq_enable (tx_irq_enable),
    .errors        (errors),
    .outstanding   (outstanding)
  );

  // Offers one event beat and returns at the clock edge that accepts it. An idle
  // burst may come first; otherwise valid stays high straight into the next beat,
  // so only the payload changes at that edge.
  task automatic send_event(input logic [OP_W-1:0] code, input logic [7:0] rxd,
                            input logic ferr, input logic [7:0] wrd, input logic treg);
    if (idle_level != 0 && $urandom_range(0, (idle_level == 1) ? 9 : 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= code;
    rx_byte      <= rxd;
    frame_error  <= ferr;
    write_byte   <= wrd;
    tx_reg_empty <= treg;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  // Drops valid and waits until every result that is owed has come back. The
  // extra edge keeps the lowering and any later raising of valid in separate steps.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // The result side stalls in bursts, at the same intensity as the event side.
  initial begin
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (idle_level != 0 && $urandom_range(0, (idle_level == 1) ? 9 : 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // A run that stalls for good ends here with a failure.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    traffic_t        mode;
    logic [OP_W-1:0] main_code;
    logic [OP_W-1:0] code;
    int              pick;

    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = OP_RX_BYTE;
    rx_byte      = '0;
    frame_error  = 1'b0;
    write_byte   = '0;
    tx_reg_empty = 1'b0;
    idle_level   = 1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed opening. Both rings start out empty, so the empty-ring cases come
    // first, then the direct write, queued writes and their drain, and finally the
    // receive side with extreme bytes, a frame error and a disable.
    send_event(OP_READ,    8'h00, 1'b0, 8'h00, 1'b1);
    send_event(OP_TX_RDY,  8'hFF, 1'b1, 8'hFF, 1'b1);
    send_event(OP_WRITE,   8'h00, 1'b0, 8'hFF, 1'b1);
    send_event(OP_WRITE,   8'hFF, 1'b1, 8'h00, 1'b0);
    send_event(OP_WRITE,   8'h00, 1'b0, 8'hA5, 1'b1);
    send_event(OP_TX_RDY,  8'h00, 1'b0, 8'h00, 1'b0);
    send_event(OP_TX_RDY,  8'h00, 1'b0, 8'h00, 1'b0);
    send_event(OP_TX_RDY,  8'h00, 1'b0, 8'h00, 1'b1);
    send_event(OP_RX_BYTE, 8'h00, 1'b0, 8'hFF, 1'b0);
    send_event(OP_RX_BYTE, 8'hFF, 1'b0, 8'h00, 1'b1);
    send_event(OP_RX_BYTE, 8'h5A, 1'b1, 8'h00, 1'b0);
    send_event(OP_RX_BYTE, 8'hFF, 1'b1, 8'h00, 1'b0);
    send_event(OP_READ,    8'h00, 1'b0, 8'h00, 1'b0);
    send_event(OP_RX_BYTE, 8'h3C, 1'b0, 8'h00, 1'b0);
    send_event(OP_DISABLE, 8'h00, 1'b0, 8'h00, 1'b0);
    send_event(OP_READ,    8'h00, 1'b0, 8'h00, 1'b0);
    // Unused codes must leave everything as it was.
    for (int c = OP_DISABLE + 1; c < (1 << OP_W); c++) begin
      send_event(c[OP_W-1:0], 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end

    // Random part, in segments. The first four walk both rings to full and back to
    // empty in a fixed order; later segments pick a shape at random. Every fourth
    // segment begins with the event side held off until the results have drained.
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      case (seg)
        0: begin
          mode = FILL_RX;
        end
        1: begin
          mode = FILL_TX;
        end
        2: begin
          mode = DRAIN_RX;
        end
        3: begin
          mode = DRAIN_TX;
        end
        default: begin
          mode = traffic_t'($urandom_range(MIXED_TRAFFIC, DRAIN_TX));
        end
      endcase
      idle_level = (seg >= NUM_SEGMENTS - CALM_SEGMENTS) ? 0 : $urandom_range(0, 2);
      if (seg % 4 == 0) begin
        wait_for_drain();
      end

      for (int i = 0; i < SEG_ITEMS; i++) begin
        case (mode)
          FILL_RX: begin
            main_code = OP_RX_BYTE;
          end
          DRAIN_RX: begin
            main_code = OP_READ;
          end
          FILL_TX: begin
            main_code = OP_WRITE;
          end
          DRAIN_TX: begin
            main_code = OP_TX_RDY;
          end
          default: begin
            main_code = OP_W'($urandom_range(OP_RX_BYTE, OP_TX_RDY));
          end
        endcase
        // Mostly the segment's own event kind, some of every other kind, a disable
        // only where it cannot spoil a fill, and a sprinkling of unused codes.
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          code = main_code;
        end else if (pick < 95) begin
          code = OP_W'($urandom_range(OP_RX_BYTE, OP_TX_RDY));
        end else if (pick < 97) begin
          code = (mode == MIXED_TRAFFIC || mode == DRAIN_RX) ? OP_DISABLE : main_code;
        end else begin
          code = OP_W'($urandom_range(OP_DISABLE + 1, (1 << OP_W) - 1));
        end
        // While filling the transmit ring the data register is mostly busy, so that
        // writes queue rather than go straight to the line.
        send_event(code, 8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                   8'($urandom_range(0, 255)),
                   (mode == FILL_TX) ? ($urandom_range(0, 3) == 0)
                                     : 1'($urandom_range(0, 1)));
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
